FILE: hdl/cftr_pkg.sv
`timescale 1ns / 1ps

package cftr_pkg;

  localparam int FONT_BYTES = 1024;
  localparam int FA_W       = $clog2(FONT_BYTES);
  localparam int BASE_W     = 11;
  localparam int RA_W       = (FA_W > BASE_W) ? FA_W : BASE_W;

  localparam logic [7:0] CODE_NEWLINE   = 8'h0A;
  localparam logic [7:0] CODE_BACKSPACE = 8'h08;
  localparam logic [7:0] CODE_FIRST     = 8'd32;

  typedef enum logic [1:0] {
    KIND_FONT_WRITE = 2'd0,
    KIND_CHAR       = 2'd1,
    KIND_SET_CURSOR = 2'd2,
    KIND_NONE       = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    REG_GLYPH_WIDTH   = 2'd0,
    REG_GLYPH_HEIGHT  = 2'd1,
    REG_SCREEN_WIDTH  = 2'd2,
    REG_SCREEN_HEIGHT = 2'd3
  } reg_idx_t;

  typedef enum logic [2:0] {
    STEP_FETCH   = 3'd0,
    STEP_DECODE  = 3'd1,
    STEP_READ    = 3'd2,
    STEP_EMIT    = 3'd3,
    STEP_ADVANCE = 3'd4
  } step_t;

  typedef enum logic [2:0] {
    JMP_NEVER,
    JMP_ALWAYS,
    JMP_NO_ACCEPT,
    JMP_NOT_GLYPH,
    JMP_NOT_LAST_FIRE
  } jump_t;

  typedef struct packed {
    logic  take;     // accept an input word
    logic  decode;   // font write, cursor set, newline, backspace, glyph base
    logic  read;     // issue the read of glyph column 0
    logic  emit;     // emit one column per free output slot
    logic  advance;  // move cursor past the glyph
    jump_t jump;
    step_t target;
  } ctrl_word_t;

  function automatic ctrl_word_t ucode(input step_t step);
    ctrl_word_t cw;
    cw = '{take: 1'b0, decode: 1'b0, read: 1'b0, emit: 1'b0, advance: 1'b0,
           jump: JMP_ALWAYS, target: STEP_FETCH};
    unique case (step)
      STEP_FETCH: begin
        cw.take   = 1'b1;
        cw.jump   = JMP_NO_ACCEPT;
        cw.target = STEP_FETCH;
      end
      STEP_DECODE: begin
        cw.decode = 1'b1;
        cw.jump   = JMP_NOT_GLYPH;
        cw.target = STEP_FETCH;
      end
      STEP_READ: begin
        cw.read = 1'b1;
        cw.jump = JMP_NEVER;
      end
      STEP_EMIT: begin
        cw.emit   = 1'b1;
        cw.jump   = JMP_NOT_LAST_FIRE;
        cw.target = STEP_EMIT;
      end
      STEP_ADVANCE: begin
        cw.advance = 1'b1;
        cw.jump    = JMP_ALWAYS;
        cw.target  = STEP_FETCH;
      end
      default: begin
        cw.jump   = JMP_ALWAYS;
        cw.target = STEP_FETCH;
      end
    endcase
    return cw;
  endfunction

  function automatic logic [3:0] clamp_glyph(input logic [3:0] v);
    if (v == 4'd0) return 4'd1;
    if (v > 4'd8) return 4'd8;
    return v;
  endfunction

endpackage

FILE: hdl/column_font_text_renderer.sv
`timescale 1ns / 1ps

// Column font text renderer.
// Input stream (in_*): one word per command; in_tuser is the kind: font byte
// write, character, or set cursor. Font bytes must be loaded before glyphs
// that use them are printed. Each printable character (and backspace, which
// draws a space) yields one output word per glyph column: screen column, top
// row, clipped row mask and color; out_tlast marks the glyph's last column.
// Newline and set cursor only move the cursor; other codes are dropped.
// A command is taken in one cycle and decoded in the next; writes, cursor moves
// and ignored codes then return to fetch. A glyph reads column 0, emits its
// columns with each font read overlapped with the emission of the previous
// column, and updates the cursor. The pace is set by the single font store read
// port and the step program. A stalled receiver holds the output register and
// halts the column loop; no word is dropped. Reset (rst_n low, synchronous)
// homes the cursor, loads the default geometry and clears the output valid;
// font contents are undefined until written. Configuration writes (cfg_*) are
// for the user to make only when idle; the block does not enforce this.
module column_font_text_renderer
  import cftr_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // font_address[9:0], font_byte[17:10], char_code[25:18], new_x[33:26],
  // new_y[41:34], ink[42], zero fill above
  input  logic [47:0] in_tdata,
  // kind[1:0]
  input  logic [1:0]  in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // column_x[7:0], row_top[15:8], pixel_mask[23:16], pixel_color[24],
  // zero fill above
  output logic [31:0] out_tdata,
  output logic        out_tlast,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_data
);

  logic [3:0] glyph_w_r, glyph_h_r;
  logic [7:0] scr_w_r, scr_h_r;
  logic [7:0] col_r, col_nxt, row_r, row_nxt;

  step_t      step_r, step_nxt;
  ctrl_word_t cw;
  logic       jump_taken;

  kind_t      kind_r;
  logic [9:0] faddr_r;
  logic [7:0] fbyte_r, code_r;
  logic [7:0] new_x_r, new_y_r;
  logic       ink_r;

  logic [BASE_W-1:0] base_r, base_nxt;
  logic [2:0]        k_r, k_nxt;

  logic [7:0] font_mem [FONT_BYTES];
  logic [7:0] rd_data_r;
  logic [RA_W-1:0] rd_addr, wr_addr;
  logic [3:0] rd_col;
  logic       rd_en, wr_en;

  logic       out_valid_r;
  logic [7:0] out_x_r, out_row_r, out_mask_r;
  logic       out_color_r, out_last_r;

  logic [3:0] w_eff, h_eff;
  logic       accept, fire, is_glyph, is_bs, is_nl, last_col;
  logic [8:0] x_sum, row_step, col_step, bs_step;
  logic [7:0] mask;
  logic [7:0] x_sat;
  logic [6:0] glyph_idx;

  assign w_eff = clamp_glyph(glyph_w_r);
  assign h_eff = clamp_glyph(glyph_h_r);
  assign cw    = ucode(step_r);

  assign in_tready = cw.take;
  assign accept    = in_tvalid && cw.take;
  assign fire      = cw.emit && (!out_valid_r || out_tready);
  assign last_col  = ({1'b0, k_r} == (w_eff - 4'd1));

  assign is_nl    = (kind_r == KIND_CHAR) && (code_r == CODE_NEWLINE);
  assign is_bs    = (kind_r == KIND_CHAR) && (code_r == CODE_BACKSPACE);
  assign is_glyph = (kind_r == KIND_CHAR)
                 && (is_bs || (code_r >= CODE_FIRST && !code_r[7]));

  always_comb begin
    unique case (cw.jump)
      JMP_NEVER:         jump_taken = 1'b0;
      JMP_ALWAYS:        jump_taken = 1'b1;
      JMP_NO_ACCEPT:     jump_taken = !accept;
      JMP_NOT_GLYPH:     jump_taken = !is_glyph;
      JMP_NOT_LAST_FIRE: jump_taken = !(fire && last_col);
      default:           jump_taken = 1'b1;
    endcase
    step_nxt = jump_taken ? cw.target : step_t'(step_r + 3'd1);
  end

  // cursor arithmetic
  assign row_step = {1'b0, row_r} + {5'd0, h_eff} + 9'd1;
  assign col_step = {1'b0, col_r} + {5'd0, w_eff} + 9'd1;
  assign bs_step  = {1'b0, col_r} - ({5'd0, w_eff} + 9'd1);
  assign glyph_idx = is_bs ? 7'd0 : 7'(code_r - CODE_FIRST);

  always_comb begin
    col_nxt  = col_r;
    row_nxt  = row_r;
    base_nxt = base_r;
    if (cw.decode) begin
      base_nxt = BASE_W'(glyph_idx) * BASE_W'(w_eff);
      if (kind_r == KIND_SET_CURSOR) begin
        col_nxt = new_x_r;
        row_nxt = new_y_r;
      end else if (is_nl) begin
        col_nxt = 8'd0;
        row_nxt = row_step[8] ? 8'hFF : row_step[7:0];
      end else if (is_bs) begin
        col_nxt = ({1'b0, col_r} > ({5'd0, w_eff} + 9'd1)) ? bs_step[7:0] : 8'd0;
      end
    end
    if (cw.advance) begin
      if (col_step >= {1'b0, scr_w_r}) begin
        col_nxt = 8'd0;
        row_nxt = row_step[8] ? 8'hFF : row_step[7:0];
      end else begin
        col_nxt = col_step[7:0];
      end
    end
  end

  always_comb begin
    k_nxt = k_r;
    if (cw.read) k_nxt = 3'd0;
    else if (fire) k_nxt = k_r + 3'd1;
  end

  // font store: column k is read ahead of its emission
  assign rd_col  = cw.read ? 4'd0 : ({1'b0, k_r} + 4'd1);
  assign rd_en   = cw.read || fire;
  assign rd_addr = RA_W'(base_r) + RA_W'(rd_col);
  assign wr_addr = RA_W'(faddr_r);
  assign wr_en   = cw.decode && (kind_r == KIND_FONT_WRITE) && (wr_addr < RA_W'(FONT_BYTES));

  always_ff @(posedge clk) begin
    if (wr_en) font_mem[wr_addr[FA_W-1:0]] <= fbyte_r;
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      if (rd_addr < RA_W'(FONT_BYTES)) rd_data_r <= font_mem[rd_addr[FA_W-1:0]];
      else rd_data_r <= 8'd0;
    end
  end

  // row mask: mask bit r reads font bit (h - r), clipped to the screen
  assign x_sum = {1'b0, col_r} + {6'd0, k_r};
  assign x_sat = x_sum[8] ? 8'hFF : x_sum[7:0];

  always_comb begin
    logic [15:0] byte16;
    logic [3:0]  bidx;
    logic [8:0]  row_sum;
    byte16 = {8'd0, rd_data_r};
    for (int r = 0; r < 8; r++) begin
      row_sum = {1'b0, row_r} + 9'(r);
      bidx    = h_eff - 4'(r);
      mask[r] = (4'(r) < h_eff) && byte16[bidx]
             && (x_sum < {1'b0, scr_w_r}) && (row_sum < {1'b0, scr_h_r});
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r      <= STEP_FETCH;
      col_r       <= 8'd0;
      row_r       <= 8'd0;
      out_valid_r <= 1'b0;
      glyph_w_r   <= 4'd5;
      glyph_h_r   <= 4'd7;
      scr_w_r     <= 8'd84;
      scr_h_r     <= 8'd48;
    end else begin
      step_r <= step_nxt;
      col_r  <= col_nxt;
      row_r  <= row_nxt;
      if (fire) out_valid_r <= 1'b1;
      else if (out_tready) out_valid_r <= 1'b0;
      if (cfg_we) begin
        unique case (reg_idx_t'(cfg_index))
          REG_GLYPH_WIDTH:   glyph_w_r <= cfg_data[3:0];
          REG_GLYPH_HEIGHT:  glyph_h_r <= cfg_data[3:0];
          REG_SCREEN_WIDTH:  scr_w_r   <= cfg_data;
          REG_SCREEN_HEIGHT: scr_h_r   <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    base_r <= base_nxt;
    k_r    <= k_nxt;
    if (accept) begin
      kind_r  <= kind_t'(in_tuser);
      faddr_r <= in_tdata[9:0];
      fbyte_r <= in_tdata[17:10];
      code_r  <= in_tdata[25:18];
      new_x_r <= in_tdata[33:26];
      new_y_r <= in_tdata[41:34];
      ink_r   <= in_tdata[42];
    end
    if (fire) begin
      out_x_r     <= x_sat;
      out_row_r   <= row_r;
      out_mask_r  <= mask;
      out_color_r <= ink_r;
      out_last_r  <= last_col;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'd0, out_color_r, out_mask_r, out_row_r, out_x_r};
  assign out_tlast  = out_last_r;

endmodule

FILE: test/column_font_text_renderer_tb.sv
`timescale 1ns / 1ps

module column_font_text_renderer_tb;
  import cftr_pkg::*;

  localparam logic [7:0] CODE_END       = 8'h80;
  localparam int         PHASE_ITEMS    = 55;
  localparam int         BACKLOG_CYCLES = 200;
  localparam int         SETTLE_CYCLES  = 16;
  localparam int         LIMIT_NS       = 6_000_000;

  typedef struct packed {
    logic [7:0] column_x;
    logic [7:0] row_top;
    logic [7:0] pixel_mask;
    logic       pixel_color;
    logic       last_column;
  } pixel_cmd_t;

  typedef struct packed {
    kind_t             kind;
    logic [9:0]        addr;
    logic [7:0]        fbits;
    logic [7:0]        code;
    logic [7:0]        nx;
    logic [7:0]        ny;
    logic              ink;
    logic signed [4:0] t_n;   // typed column count, negative: use the predictor
    logic [7:0]        t_x;
    logic [7:0]        t_row;
    logic [7:0]        t_mask;
  } stim_row_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [47:0] in_tdata;
  logic [1:0]  in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  logic [31:0] out_tdata;
  logic        out_tlast;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [7:0]  cfg_data;

  // predictor state
  logic [3:0] gw, gh;
  logic [7:0] sw, sh;
  int         cur_col, cur_row;
  logic [7:0] glyph_mem [FONT_BYTES];
  bit         font_loaded [FONT_BYTES];

  pixel_cmd_t col_q [$];
  stim_row_t  plan [$];

  int errors;
  int words_sent;
  int cols_seen;
  int geometries;
  int tx_calm;
  int rx_calm;
  int rx_wait;
  int backlog_req;
  int backlog_seen;

  column_font_text_renderer uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #(LIMIT_NS);
    $display("FAIL column_font_text_renderer");
    $finish;
  end

  function automatic int glyph_dim(logic [3:0] v);
    if (v == 4'd0) return 1;
    if (v > 4'd8) return 8;
    return v;
  endfunction

  function automatic int sat8(int v);
    return (v > 255) ? 255 : v;
  endfunction

  // mostly short gaps, a few long ones, and now and then a calm stretch
  function automatic int idle_len(inout int calm);
    int r;
    if (calm > 0) begin
      calm--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 3) begin
      calm = $urandom_range(20, 60);
      return 0;
    end
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Apply one input word to the model; queue the pixel columns it draws.
  function automatic int render_word(kind_t kind, logic [47:0] word);
    int         w, h, x, base, n;
    logic [7:0] code, font_bits, mask;
    pixel_cmd_t cmd;
    w = glyph_dim(gw);
    h = glyph_dim(gh);
    n = 0;
    case (kind)
      KIND_FONT_WRITE: begin
        glyph_mem[word[9:0]] = word[17:10];
      end
      KIND_SET_CURSOR: begin
        cur_col = word[33:26];
        cur_row = word[41:34];
      end
      KIND_CHAR: begin
        code = word[25:18];
        if (code == CODE_NEWLINE) begin
          cur_col = 0;
          cur_row = sat8(cur_row + h + 1);
        end else begin
          if (code == CODE_BACKSPACE) begin
            cur_col = (cur_col > w + 1) ? cur_col - (w + 1) : 0;
            code    = CODE_FIRST;
          end
          if (code >= CODE_FIRST && code < CODE_END) begin
            base = (code - CODE_FIRST) * w;
            for (int k = 0; k < w; k++) begin
              x         = cur_col + k;
              font_bits = glyph_mem[base + k];
              mask      = '0;
              // row r reads column bit h - r; bit 8 is never set
              for (int r = 0; r < h; r++)
                if ((h - r) < 8 && font_bits[h - r] && x < sw && cur_row + r < sh)
                  mask[r] = 1'b1;
              cmd.column_x    = (x > 255) ? 8'd255 : x[7:0];
              cmd.row_top     = cur_row[7:0];
              cmd.pixel_mask  = mask;
              cmd.pixel_color = word[42];
              cmd.last_column = (k == w - 1);
              col_q.push_back(cmd);
              n++;
            end
            if (cur_col + w + 1 >= sw) begin
              cur_col = 0;
              cur_row = sat8(cur_row + h + 1);
            end else begin
              cur_col = cur_col + w + 1;
            end
          end
        end
      end
      default: ;
    endcase
    return n;
  endfunction

  task automatic flag_mismatch(string what, int got, int want);
    $display("mismatch at column %0d: %s got 0x%0h want 0x%0h", cols_seen, what, got, want);
    errors++;
  endtask

  // Offer one word; update the model at the edge it is taken.
  task automatic send_word(kind_t kind, logic [47:0] word, int typed_n,
                           logic [7:0] t_x, logic [7:0] t_row, logic [7:0] t_mask);
    int         gap, n;
    pixel_cmd_t cmd;
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= word;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    n = render_word(kind, word);
    if (typed_n >= 0) begin
      repeat (n) void'(col_q.pop_back());
      for (int i = 0; i < typed_n; i++) begin
        cmd.column_x    = t_x + 8'(i);
        cmd.row_top     = t_row;
        cmd.pixel_mask  = t_mask;
        cmd.pixel_color = word[42];
        cmd.last_column = (i == typed_n - 1);
        col_q.push_back(cmd);
      end
    end
    if (kind == KIND_FONT_WRITE) font_loaded[word[9:0]] = 1'b1;
    words_sent++;
    gap = idle_len(tx_calm);
    if (gap > 0) begin
      @(negedge clk);
      in_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  task automatic settle(int extra);
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (col_q.size() != 0) @(posedge clk);
    repeat (extra) @(posedge clk);
  endtask

  task automatic write_reg(reg_idx_t idx, logic [7:0] v);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= v;
    case (idx)
      REG_GLYPH_WIDTH:   gw = v[3:0];
      REG_GLYPH_HEIGHT:  gh = v[3:0];
      REG_SCREEN_WIDTH:  sw = v;
      REG_SCREEN_HEIGHT: sh = v;
      default: ;
    endcase
  endtask

  task automatic apply_geometry(logic [7:0] gw_v, logic [7:0] gh_v,
                                logic [7:0] sw_v, logic [7:0] sh_v);
    settle(SETTLE_CYCLES);
    write_reg(REG_GLYPH_WIDTH, gw_v);
    write_reg(REG_GLYPH_HEIGHT, gh_v);
    write_reg(REG_SCREEN_WIDTH, sw_v);
    write_reg(REG_SCREEN_HEIGHT, sh_v);
    @(negedge clk);
    cfg_we <= 1'b0;
    geometries++;
  endtask

  // Write any glyph bytes not yet loaded, so no unwritten entry is read.
  task automatic load_glyph(logic [7:0] code);
    int          w, base;
    logic [47:0] word;
    w    = glyph_dim(gw);
    base = (code - CODE_FIRST) * w;
    for (int k = 0; k < w; k++) begin
      if (!font_loaded[base + k]) begin
        word        = {$urandom, $urandom};
        word[47:43] = '0;
        word[9:0]   = 10'(base + k);
        send_word(KIND_FONT_WRITE, word, -1, 8'd0, 8'd0, 8'd0);
      end
    end
  endtask

  // every word counts toward the phase, font loads included
  task automatic random_phase(int count);
    int          r, start;
    bit          held, paused;
    logic [7:0]  code;
    logic [47:0] word;
    start  = words_sent;
    held   = 1'b0;
    paused = 1'b0;
    while (words_sent - start < count) begin
      word        = {$urandom, $urandom};
      word[47:43] = '0;
      r           = $urandom_range(0, 99);
      if (!held && words_sent - start >= 15) begin
        backlog_req++;
        held = 1'b1;
      end
      if (!paused && words_sent - start >= 40) begin
        settle(0);
        paused = 1'b1;
      end
      if (r < 58) begin
        code = 8'($urandom_range(CODE_FIRST, CODE_END - 1));
        load_glyph(code);
        word[25:18] = code;
        send_word(KIND_CHAR, word, -1, 8'd0, 8'd0, 8'd0);
      end else if (r < 64) begin
        load_glyph(CODE_FIRST);
        word[25:18] = CODE_BACKSPACE;
        send_word(KIND_CHAR, word, -1, 8'd0, 8'd0, 8'd0);
      end else if (r < 70) begin
        word[25:18] = CODE_NEWLINE;
        send_word(KIND_CHAR, word, -1, 8'd0, 8'd0, 8'd0);
      end else if (r < 76) begin
        do code = 8'($urandom_range(0, 255));
        while (!((code < CODE_FIRST && code != CODE_NEWLINE && code != CODE_BACKSPACE)
                 || code >= CODE_END));
        word[25:18] = code;
        send_word(KIND_CHAR, word, -1, 8'd0, 8'd0, 8'd0);
      end else if (r < 89) begin
        // keep most cursor moves on screen
        if ($urandom_range(0, 1)) begin
          word[33:26] = 8'($urandom_range(0, sw - 1));
          word[41:34] = 8'($urandom_range(0, sh - 1));
        end
        send_word(KIND_SET_CURSOR, word, -1, 8'd0, 8'd0, 8'd0);
      end else if (r < 96) begin
        send_word(KIND_FONT_WRITE, word, -1, 8'd0, 8'd0, 8'd0);
      end else begin
        send_word(KIND_NONE, word, -1, 8'd0, 8'd0, 8'd0);
      end
    end
  endtask

  function automatic stim_row_t plan_row(kind_t kind, logic [9:0] addr, logic [7:0] fbits,
                                         logic [7:0] code, logic [7:0] nx, logic [7:0] ny,
                                         logic ink, int t_n, logic [7:0] t_x,
                                         logic [7:0] t_row, logic [7:0] t_mask);
    stim_row_t s;
    s.kind   = kind;
    s.addr   = addr;
    s.fbits  = fbits;
    s.code   = code;
    s.nx     = nx;
    s.ny     = ny;
    s.ink    = ink;
    s.t_n    = 5'(t_n);
    s.t_x    = t_x;
    s.t_row  = t_row;
    s.t_mask = t_mask;
    return s;
  endfunction

  // receiver: random ready gaps, plus one long hold per backlog request
  initial begin
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (backlog_req != backlog_seen) begin
        backlog_seen = backlog_req;
        out_tready <= 1'b0;
        repeat (BACKLOG_CYCLES) @(negedge clk);
      end
      if (rx_wait > 0) begin
        out_tready <= 1'b0;
        rx_wait--;
      end else begin
        out_tready <= 1'b1;
        rx_wait = idle_len(rx_calm);
      end
    end
  end

  always @(posedge clk) begin : watch_columns
    pixel_cmd_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (col_q.size() == 0) begin
        flag_mismatch("column with none pending", out_tdata[7:0], 0);
      end else begin
        want = col_q.pop_front();
        if (out_tdata[7:0] != want.column_x)
          flag_mismatch("column_x", out_tdata[7:0], want.column_x);
        if (out_tdata[15:8] != want.row_top)
          flag_mismatch("row_top", out_tdata[15:8], want.row_top);
        if (out_tdata[23:16] != want.pixel_mask)
          flag_mismatch("pixel_mask", out_tdata[23:16], want.pixel_mask);
        if (out_tdata[24] != want.pixel_color)
          flag_mismatch("pixel_color", out_tdata[24], want.pixel_color);
        if (out_tlast != want.last_column)
          flag_mismatch("last_column", out_tlast, want.last_column);
      end
      cols_seen++;
    end
  end

  initial begin : stimulus
    logic [47:0] word;
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    in_tuser  = KIND_FONT_WRITE;
    cfg_we    = 1'b0;
    cfg_index = REG_GLYPH_WIDTH;
    cfg_data  = '0;
    gw        = 4'd5;
    gh        = 4'd7;
    sw        = 8'd84;
    sh        = 8'd48;
    cur_col   = 0;
    cur_row   = 0;
    errors    = 0;
    words_sent = 0;
    cols_seen  = 0;
    geometries = 1;
    tx_calm    = 0;
    rx_calm    = 0;
    rx_wait    = 0;
    backlog_req  = 0;
    backlog_seen = 0;

    // solid space glyph, then space, clamped and plain backspace
    for (int a = 0; a < 5; a++)
      plan.push_back(plan_row(KIND_FONT_WRITE, 10'(a), 8'hFF, 8'h00, 8'h00, 8'h00, 1'b0,
                              0, 8'd0, 8'd0, 8'd0));
    plan.push_back(plan_row(KIND_CHAR, 10'd0, 8'h00, CODE_FIRST, 8'h00, 8'h00, 1'b1,
                            5, 8'd0, 8'd0, 8'h7F));
    plan.push_back(plan_row(KIND_CHAR, 10'd0, 8'h00, CODE_BACKSPACE, 8'h00, 8'h00, 1'b0,
                            5, 8'd0, 8'd0, 8'h7F));
    plan.push_back(plan_row(KIND_SET_CURSOR, 10'd0, 8'h00, 8'h00, 8'd20, 8'd0, 1'b0,
                            0, 8'd0, 8'd0, 8'd0));
    plan.push_back(plan_row(KIND_CHAR, 10'd0, 8'h00, CODE_BACKSPACE, 8'h00, 8'h00, 1'b1,
                            5, 8'd14, 8'd0, 8'h7F));
    plan.push_back(plan_row(KIND_CHAR, 10'd0, 8'h00, CODE_NEWLINE, 8'h00, 8'h00, 1'b1,
                            0, 8'd0, 8'd0, 8'd0));
    // dropped codes and the unused kind
    plan.push_back(plan_row(KIND_CHAR, 10'd0, 8'h00, 8'h00, 8'h00, 8'h00, 1'b1,
                            0, 8'd0, 8'd0, 8'd0));
    plan.push_back(plan_row(KIND_CHAR, 10'd0, 8'h00, 8'h1F, 8'h00, 8'h00, 1'b1,
                            0, 8'd0, 8'd0, 8'd0));
    plan.push_back(plan_row(KIND_CHAR, 10'd0, 8'h00, CODE_END, 8'h00, 8'h00, 1'b1,
                            0, 8'd0, 8'd0, 8'd0));
    plan.push_back(plan_row(KIND_CHAR, 10'd0, 8'h00, 8'hFF, 8'h00, 8'h00, 1'b1,
                            0, 8'd0, 8'd0, 8'd0));
    plan.push_back(plan_row(KIND_NONE, 10'h3FF, 8'hFF, CODE_FIRST, 8'hFF, 8'hFF, 1'b1,
                            0, 8'd0, 8'd0, 8'd0));
    plan.push_back(plan_row(KIND_FONT_WRITE, 10'h3FF, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0,
                            0, 8'd0, 8'd0, 8'd0));
    // tilde glyph with bit 0 only, top bit, and alternating columns
    plan.push_back(plan_row(KIND_FONT_WRITE, 10'd470, 8'h01, 8'h00, 8'h00, 8'h00, 1'b0,
                            -1, 8'd0, 8'd0, 8'd0));
    plan.push_back(plan_row(KIND_FONT_WRITE, 10'd471, 8'h80, 8'h00, 8'h00, 8'h00, 1'b0,
                            -1, 8'd0, 8'd0, 8'd0));
    plan.push_back(plan_row(KIND_FONT_WRITE, 10'd472, 8'hAA, 8'h00, 8'h00, 8'h00, 1'b0,
                            -1, 8'd0, 8'd0, 8'd0));
    plan.push_back(plan_row(KIND_FONT_WRITE, 10'd473, 8'h55, 8'h00, 8'h00, 8'h00, 1'b0,
                            -1, 8'd0, 8'd0, 8'd0));
    plan.push_back(plan_row(KIND_FONT_WRITE, 10'd474, 8'hFE, 8'h00, 8'h00, 8'h00, 1'b0,
                            -1, 8'd0, 8'd0, 8'd0));
    // clip at right and bottom edge, then saturate column and row
    plan.push_back(plan_row(KIND_SET_CURSOR, 10'd0, 8'h00, 8'h00, 8'd82, 8'd45, 1'b0,
                            -1, 8'd0, 8'd0, 8'd0));
    plan.push_back(plan_row(KIND_CHAR, 10'd0, 8'h00, 8'h7E, 8'h00, 8'h00, 1'b1,
                            -1, 8'd0, 8'd0, 8'd0));
    plan.push_back(plan_row(KIND_SET_CURSOR, 10'd0, 8'h00, 8'h00, 8'hFF, 8'hFF, 1'b0,
                            0, 8'd0, 8'd0, 8'd0));
    plan.push_back(plan_row(KIND_CHAR, 10'd0, 8'h00, CODE_FIRST, 8'h00, 8'h00, 1'b0,
                            -1, 8'd0, 8'd0, 8'd0));
    plan.push_back(plan_row(KIND_CHAR, 10'd0, 8'h00, CODE_NEWLINE, 8'h00, 8'h00, 1'b0,
                            0, 8'd0, 8'd0, 8'd0));
    plan.push_back(plan_row(KIND_CHAR, 10'd0, 8'h00, 8'h7E, 8'h00, 8'h00, 1'b1,
                            -1, 8'd0, 8'd0, 8'd0));

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (plan[i]) begin
      word = {5'b0, plan[i].ink, plan[i].ny, plan[i].nx, plan[i].code,
              plan[i].fbits, plan[i].addr};
      send_word(plan[i].kind, word, plan[i].t_n, plan[i].t_x, plan[i].t_row,
                plan[i].t_mask);
    end
    random_phase(PHASE_ITEMS);

    // width 0 and height 15 clamp; upper nibble of the glyph registers drops
    apply_geometry(8'h00, 8'h0F, 8'd255, 8'd255);
    random_phase(PHASE_ITEMS);
    apply_geometry(8'hF8, 8'h01, 8'd1, 8'd1);
    random_phase(PHASE_ITEMS);
    apply_geometry(8'h03, 8'hF5, 8'd40, 8'd30);
    random_phase(PHASE_ITEMS);
    apply_geometry(8'h08, 8'h08, 8'd84, 8'd48);
    random_phase(PHASE_ITEMS);
    apply_geometry(8'h15, 8'h07, 8'd84, 8'd48);
    random_phase(PHASE_ITEMS);

    settle(SETTLE_CYCLES);
    $display("Sent %0d input words over %0d geometry settings; checked %0d pixel columns.",
             words_sent, geometries, cols_seen);
    $display("Run included clamped glyph sizes, edge clipping, cursor saturation and backlog.");
    if (errors == 0) begin
      $display("PASS column_font_text_renderer");
    end else begin
      $display("FAIL column_font_text_renderer");
    end
    $finish;
  end

endmodule
